// ===== rtl/wcrc_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the word CRC-8 deframer.
package wcrc_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   // byte position within a three-byte group
   typedef enum logic [1:0] {
      PHASE_HIGH  = 2'd0,
      PHASE_LOW   = 2'd1,
      PHASE_CHECK = 2'd2
   } wcrc_phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
      logic       frame_end;
   } wcrc_item_type;

   typedef struct packed {
      logic [15:0] data_word;
      logic        word_crc_ok;
      logic        frame_good;
      logic        last_word;
   } wcrc_result_type;

   // One unrolled CRC-8 byte update, MSB first.
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/wcrc_in_stage.sv =====
// Input register stage: captures one transaction and holds it until the core consumes it.
module wcrc_in_stage
   import wcrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  wcrc_item_type req_item,
   output logic          item_valid,
   output wcrc_item_type item,
   input  logic          item_consume
);

   logic          valid_ff, valid_in;
   wcrc_item_type item_ff;
   logic          take;

   // accept when empty or when the held item leaves this cycle
   assign req_ready = !valid_ff || item_consume;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (item_consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load payload on accept
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/wcrc_frame_core.sv =====
// Frame state and CRC check: turns one held byte into at most one result.
module wcrc_frame_core
   import wcrc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  wcrc_item_type   item,
   output logic            item_consume,
   input  logic            res_space,
   output logic            res_valid,
   output wcrc_result_type res
);

   wcrc_phase_type phase_ff, phase_in;
   logic [7:0]     crc_ff, crc_in;
   logic [7:0]     high_ff, high_in;
   logic [7:0]     low_ff, low_in;
   logic           err_ff, err_in;

   wcrc_phase_type phase_eff;
   logic [7:0]     crc_eff;
   logic           err_eff;
   logic           emit;
   logic           ok;

   // apply frame start before the byte is taken
   always_comb begin
      phase_eff = item.frame_start ? PHASE_HIGH : phase_ff;
      crc_eff   = item.frame_start ? CRC_INIT : crc_ff;
      err_eff   = item.frame_start ? 1'b0 : err_ff;
   end

   assign ok = (item.rx_byte == crc_eff);

   // next state for the held byte
   always_comb begin
      phase_in = phase_eff;
      crc_in   = crc_eff;
      err_in   = err_eff;
      high_in  = high_ff;
      low_in   = low_ff;
      case (phase_eff)
         PHASE_CHECK: begin
            phase_in = PHASE_HIGH;
            crc_in   = CRC_INIT;
            err_in   = item.frame_end ? 1'b0 : (err_eff || !ok);
         end
         PHASE_LOW: begin
            low_in   = item.rx_byte;
            crc_in   = crc_byte(crc_eff, item.rx_byte);
            phase_in = PHASE_CHECK;
         end
         default: begin
            high_in  = item.rx_byte;
            crc_in   = crc_byte(CRC_INIT, item.rx_byte);
            phase_in = PHASE_LOW;
         end
      endcase
      // clear the frame after a partial group
      if (item.frame_end && phase_eff != PHASE_CHECK) begin
         phase_in = PHASE_HIGH;
         crc_in   = CRC_INIT;
         err_in   = 1'b0;
      end
   end

   // result for the held byte
   always_comb begin
      emit = 1'b0;
      res  = '0;
      case (phase_eff)
         PHASE_CHECK: begin
            emit            = 1'b1;
            res.data_word   = {high_ff, low_ff};
            res.word_crc_ok = ok;
            res.frame_good  = ok && !err_eff;
            res.last_word   = item.frame_end;
         end
         default: begin
            // close a partial group
            if (item.frame_end) begin
               emit          = 1'b1;
               res.last_word = 1'b1;
            end
         end
      endcase
   end

   // consume unless a result is due and the output stage is full
   assign item_consume = item_valid && (!emit || res_space);
   assign res_valid    = item_valid && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HIGH;
         crc_ff   <= CRC_INIT;
         high_ff  <= 8'h00;
         low_ff   <= 8'h00;
         err_ff   <= 1'b0;
      end else if (item_consume) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== rtl/wcrc_out_stage.sv =====
// Result register stage: holds one result transaction until the receiver takes it.
module wcrc_out_stage
   import wcrc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            res_load,
   input  wcrc_result_type res,
   output logic            res_space,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output wcrc_result_type rsp_res
);

   logic            valid_ff, valid_in;
   wcrc_result_type res_ff;

   // room when empty or when the held result leaves this cycle
   assign res_space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

// ===== rtl/word_crc8_deframer_unit.sv =====
// Top level of the word CRC-8 deframer: input stage, frame core and result stage.
//
// Usage:
//   Send received response bytes on the req_ channel (valid/ready), one byte per
//   transaction, with req_frame_start on the first byte of a frame and
//   req_frame_end on its last. Every third byte of a group yields one rsp_
//   transaction carrying the big-endian word, its CRC-8 match flag and the
//   sticky frame-good flag; a frame that ends inside a group yields one closing
//   transaction with word and flags zero and rsp_last_word high.
//   Path: a check byte lands in the input register at acceptance, and its
//   result is loaded into the result register as the frame core retires the
//   byte; while the result register is full, the byte waits in the input register.
//   Throughput: one byte per cycle while no result meets a full result register;
//   the CRC byte step is unrolled logic between the input register and the core CRC register.
//   Reset: synchronous, active high; both stages empty, group phase zero, CRC
//   at its initial value, error flag clear.
//   Stall: while rsp_ready is low the result register holds; bytes that give no
//   result still pass, and req_ready drops only when a byte needing a result
//   meets a full result register.
module word_crc8_deframer_unit
   import wcrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_data_word,
   output logic        rsp_word_crc_ok,
   output logic        rsp_frame_good,
   output logic        rsp_last_word
);

   wcrc_item_type   req_item;
   wcrc_item_type   item;
   logic            item_valid;
   logic            item_consume;
   logic            res_space;
   logic            res_valid;
   wcrc_result_type res;
   wcrc_result_type rsp_res;

   always_comb begin
      req_item.rx_byte     = req_rx_byte;
      req_item.frame_start = req_frame_start;
      req_item.frame_end   = req_frame_end;
   end

   wcrc_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_item     (req_item),
      .item_valid   (item_valid),
      .item         (item),
      .item_consume (item_consume)
   );

   wcrc_frame_core u_frame_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .item_consume (item_consume),
      .res_space    (res_space),
      .res_valid    (res_valid),
      .res          (res)
   );

   // load a result only when the core actually retires its byte
   wcrc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_valid && item_consume),
      .res       (res),
      .res_space (res_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_data_word   = rsp_res.data_word;
   assign rsp_word_crc_ok = rsp_res.word_crc_ok;
   assign rsp_frame_good  = rsp_res.frame_good;
   assign rsp_last_word   = rsp_res.last_word;

endmodule

// ===== verif/testbench.sv =====
// Testbench for the word CRC-8 deframer: byte stimulus, frame predictor and result checker.
`timescale 1ns / 1ps

module testbench
   import wcrc_pkg::*;
();

   // one byte of stimulus, with an optional hand-written expectation
   typedef struct {
      wcrc_item_type   item;
      bit              pinned;
      wcrc_result_type want;
   } byte_row_type;

   localparam wcrc_result_type PARTIAL_CLOSE = {16'h0000, 1'b0, 1'b0, 1'b1};
   localparam int RANDOM_BYTES   = 800;
   localparam int QUIET_TAIL     = 100;
   localparam int LONG_HOLD      = 80;
   localparam int LATENCY_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_data_word;
   logic        rsp_word_crc_ok;
   logic        rsp_frame_good;
   logic        rsp_last_word;

   // expectation that travels with the byte currently offered
   logic            req_pinned = 1'b0;
   wcrc_result_type req_pin_result = '0;

   byte_row_type    stim_rows[$];
   wcrc_result_type pending_words[$];
   int              mismatch_count = 0;
   bit              quiet = 1'b0;
   bit              hold_off_request = 1'b0;

   // shadow copy of the frame state
   wcrc_phase_type  sh_phase;
   logic [7:0]      sh_crc;
   logic [7:0]      sh_high;
   logic [7:0]      sh_low;
   logic            sh_err;

   word_crc8_deframer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_word   (rsp_data_word),
      .rsp_word_crc_ok (rsp_word_crc_ok),
      .rsp_frame_good  (rsp_frame_good),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // CRC-8, polynomial 0x31, one input bit at a time, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ b[i];
         r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   function automatic void clear_shadow_frame();
      sh_phase = PHASE_HIGH;
      sh_crc = CRC_INIT;
      sh_err = 1'b0;
   endfunction

   // advance the shadow state by one byte; emit tells whether a result is due
   task automatic deframe_byte(input wcrc_item_type it, output bit emit,
                               output wcrc_result_type res);
      logic match;
      emit = 1'b0;
      res = '0;
      if (it.frame_start) begin
         clear_shadow_frame();
      end
      case (sh_phase)
         PHASE_CHECK: begin
            match = (it.rx_byte == sh_crc);
            res = {sh_high, sh_low, match, match & ~sh_err, it.frame_end};
            emit = 1'b1;
            if (!match) begin
               sh_err = 1'b1;
            end
            sh_phase = PHASE_HIGH;
            sh_crc = CRC_INIT;
            if (it.frame_end) begin
               clear_shadow_frame();
            end
         end
         PHASE_LOW: begin
            sh_low = it.rx_byte;
            sh_crc = crc8_update(sh_crc, it.rx_byte);
            sh_phase = PHASE_CHECK;
         end
         default: begin
            sh_high = it.rx_byte;
            sh_crc = crc8_update(CRC_INIT, it.rx_byte);
            sh_phase = PHASE_LOW;
         end
      endcase
      // close a frame that ends inside a group
      if (!emit && it.frame_end) begin
         res = PARTIAL_CLOSE;
         emit = 1'b1;
         clear_shadow_frame();
      end
   endtask

   task automatic add_row(input logic [7:0] b, input logic s, input logic e,
                          input bit pin, input wcrc_result_type want);
      byte_row_type row;
      row.item = {b, s, e};
      row.pinned = pin;
      row.want = want;
      stim_rows.push_back(row);
   endtask

   // compare one accepted result against the oldest expectation
   task automatic check_word(input wcrc_result_type got);
      wcrc_result_type exp_word;
      if (pending_words.size() == 0) begin
         $error("unexpected result: data_word %h ok %b good %b last %b",
                got.data_word, got.word_crc_ok, got.frame_good, got.last_word);
         mismatch_count++;
      end else begin
         exp_word = pending_words.pop_front();
         if (got.data_word !== exp_word.data_word) begin
            $error("data_word: expected %h, got %h", exp_word.data_word, got.data_word);
            mismatch_count++;
         end
         if (got.word_crc_ok !== exp_word.word_crc_ok) begin
            $error("word_crc_ok: expected %b, got %b", exp_word.word_crc_ok,
                   got.word_crc_ok);
            mismatch_count++;
         end
         if (got.frame_good !== exp_word.frame_good) begin
            $error("frame_good: expected %b, got %b", exp_word.frame_good, got.frame_good);
            mismatch_count++;
         end
         if (got.last_word !== exp_word.last_word) begin
            $error("last_word: expected %b, got %b", exp_word.last_word, got.last_word);
            mismatch_count++;
         end
      end
   endtask

   // check delivered results, then predict from accepted bytes
   always @(posedge clock) begin
      bit              emit;
      wcrc_result_type res;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_word({rsp_data_word, rsp_word_crc_ok, rsp_frame_good, rsp_last_word});
         end
         if (req_valid && req_ready) begin
            deframe_byte({req_rx_byte, req_frame_start, req_frame_end}, emit, res);
            if (req_pinned) begin
               pending_words.push_back(req_pin_result);
            end else if (emit) begin
               pending_words.push_back(res);
            end
         end
      end
   end

   // receiver: short random stalls, one long hold-off on request, none at the end
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // sender: build the byte table, walk it, then drain
   initial begin
      int          kind;
      int          ngroups;
      int          directed_count;
      int          tail;
      logic [15:0] w;
      logic [7:0]  chk;

      clear_shadow_frame();
      sh_high = 8'h00;
      sh_low = 8'h00;

      // one-byte frame closes as a partial group
      add_row(8'h00, 1'b1, 1'b1, 1'b1, PARTIAL_CLOSE);
      // well-known word with its correct check byte
      add_row(8'hBE, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hEF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h92, 1'b0, 1'b1, 1'b1, {16'hBEEF, 1'b1, 1'b1, 1'b1});
      // bad check byte, then a good group: the frame flag stays low
      add_row(8'hBE, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hEF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, 1'b1, {16'hBEEF, 1'b0, 1'b0, 1'b0});
      add_row(8'hBE, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hEF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h92, 1'b0, 1'b1, 1'b1, {16'hBEEF, 1'b1, 1'b0, 1'b1});
      // frame ends after two bytes
      add_row(8'h12, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h34, 1'b0, 1'b1, 1'b1, PARTIAL_CLOSE);
      // extreme byte values
      add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
      // bytes without a start, then starts that drop a partial group
      add_row(8'h56, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h78, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h9A, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hBC, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h02, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h03, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h04, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h05, 1'b0, 1'b1, 1'b0, '0);
      directed_count = stim_rows.size();

      // random frames: mostly well formed, some truncated, unterminated or noise
      while (stim_rows.size() < directed_count + RANDOM_BYTES) begin
         kind = $urandom_range(0, 9);
         if (kind == 9) begin
            repeat ($urandom_range(1, 4)) begin
               add_row(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                       1'b0, '0);
            end
         end else begin
            ngroups = $urandom_range(1, 4);
            for (int g = 0; g < ngroups; g++) begin
               w = 16'($urandom);
               chk = crc8_update(crc8_update(CRC_INIT, w[15:8]), w[7:0]);
               if ($urandom_range(0, 6) == 0) begin
                  chk = 8'($urandom);
               end
               add_row(w[15:8], g == 0, 1'b0, 1'b0, '0);
               add_row(w[7:0], 1'b0, 1'b0, 1'b0, '0);
               add_row(chk, 1'b0, (kind <= 6) && (g == ngroups - 1), 1'b0, '0);
            end
            // truncated tail: end the frame inside a new group
            if (kind == 7) begin
               tail = $urandom_range(1, 2);
               for (int t = 0; t < tail; t++) begin
                  add_row(8'($urandom), 1'b0, t == tail - 1, 1'b0, '0);
               end
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // offer each byte and hold it until accepted
      for (int i = 0; i < stim_rows.size(); i++) begin
         if (i >= stim_rows.size() - QUIET_TAIL) begin
            quiet = 1'b1;
         end
         if (i == directed_count + 250) begin
            hold_off_request = 1'b1;
         end
         if (!quiet && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_rx_byte <= stim_rows[i].item.rx_byte;
         req_frame_start <= stim_rows[i].item.frame_start;
         req_frame_end <= stim_rows[i].item.frame_end;
         req_pinned <= stim_rows[i].pinned;
         req_pin_result <= stim_rows[i].want;
         @(posedge clock);
         while (!req_ready) begin
            @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      req_pinned <= 1'b0;

      // drain outstanding results, then allow for the pipeline
      @(posedge clock);
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== word_crc8_deframer_unit.f =====
rtl/wcrc_pkg.sv
rtl/wcrc_in_stage.sv
rtl/wcrc_frame_core.sv
rtl/wcrc_out_stage.sv
rtl/word_crc8_deframer_unit.sv
verif/testbench.sv
